// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared immediate-antecedent and next-cycle checks on clk, idle under rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define GDN_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gdn assertion failed");

// consequent checked in the next cycle
`define GDN_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gdn assertion failed");

`endif

// ===== design/gdn_pkg.sv =====
// ----------------------------------------------------------------------------
// gdn_pkg
// Widths, status codes and calendar constant tables for the day number
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gdn_pkg;

  localparam int MAX_YEAR_DEF       = 4095;
  localparam int FIRST_YEAR         = 1800;
  localparam int EPOCH_YEAR         = 1601;
  localparam int DAYS_1601_TO_1800  = 72683;
  localparam int DAY_FIELD_MAX      = 1048575;

  localparam int ACC_W  = 22;   // signed day accumulator
  localparam int YR_W   = 13;   // year accumulator / remainder
  localparam int STEP_W = 4;

  // block step indices: 400y binary, 100y linear, 4y binary, 1y linear
  localparam logic [STEP_W-1:0] STEP_100_FIRST = 4'd3;
  localparam logic [STEP_W-1:0] STEP_100_LAST  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_4_FIRST   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_4_LAST    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_1_FIRST   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_LAST      = 4'd13;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_DATE = 2'd1;
  localparam logic [1:0] STAT_LOW      = 2'd2;
  localparam logic [1:0] STAT_HIGH     = 2'd3;

  function automatic int leaps_through(int y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // day number of 0 Jan of year y, elaboration only
  function automatic int days_before_year(int y);
    return (y - FIRST_YEAR) * 365 + leaps_through(y - 1) - leaps_through(FIRST_YEAR - 1);
  endfunction

  function automatic logic signed [ACC_W-1:0] step_days(logic [STEP_W-1:0] k);
    logic signed [ACC_W-1:0] r;
    case (k)
      4'd0:    r = ACC_W'(584388);
      4'd1:    r = ACC_W'(292194);
      4'd2:    r = ACC_W'(146097);
      4'd3,
      4'd4,
      4'd5:    r = ACC_W'(36524);
      4'd6:    r = ACC_W'(23376);
      4'd7:    r = ACC_W'(11688);
      4'd8:    r = ACC_W'(5844);
      4'd9:    r = ACC_W'(2922);
      4'd10:   r = ACC_W'(1461);
      4'd11,
      4'd12,
      4'd13:   r = ACC_W'(365);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [YR_W-1:0] step_years(logic [STEP_W-1:0] k);
    logic [YR_W-1:0] r;
    case (k)
      4'd0:    r = YR_W'(1600);
      4'd1:    r = YR_W'(800);
      4'd2:    r = YR_W'(400);
      4'd3,
      4'd4,
      4'd5:    r = YR_W'(100);
      4'd6:    r = YR_W'(64);
      4'd7:    r = YR_W'(32);
      4'd8:    r = YR_W'(16);
      4'd9:    r = YR_W'(8);
      4'd10:   r = YR_W'(4);
      4'd11,
      4'd12,
      4'd13:   r = YR_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // block length mod 7
  function automatic logic [2:0] step_wk(logic [STEP_W-1:0] k);
    logic [2:0] r;
    case (k)
      4'd3,
      4'd4,
      4'd5,
      4'd7,
      4'd10:   r = 3'd5;
      4'd6,
      4'd9:    r = 3'd3;
      4'd8:    r = 3'd6;
      4'd11,
      4'd12,
      4'd13:   r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   r = 5'd30;
      4'd1,
      4'd3,
      4'd5,
      4'd7,
      4'd8,
      4'd10,
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // days before the month, less the 1601..1800 span
  function automatic logic signed [ACC_W-1:0] month_base(logic [3:0] m, logic leap);
    logic [8:0]              c;
    logic signed [ACC_W-1:0] r;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    r = $signed({{(ACC_W-9){1'b0}}, c})
      + $signed({{(ACC_W-1){1'b0}}, (leap && (m > 4'd2))})
      - ACC_W'(DAYS_1601_TO_1800);
    return r;
  endfunction

  function automatic logic [2:0] add_mod7(logic [2:0] a, logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  function automatic logic [2:0] mod7_6(logic [5:0] v);
    logic [5:0] s;
    s = v;
    if (s >= 6'd28) begin
      s = s - 6'd28;
    end
    if (s >= 6'd14) begin
      s = s - 6'd14;
    end
    if (s >= 6'd7) begin
      s = s - 6'd7;
    end
    return s[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/gdn_alu.sv =====
// ----------------------------------------------------------------------------
// gdn_alu
// Shared signed add/subtract unit with sign flag, used by every arithmetic sequencer step.
// ----------------------------------------------------------------------------
`default_nettype none

module gdn_alu import gdn_pkg::*; (
  input  logic signed [ACC_W-1:0] a,
  input  logic signed [ACC_W-1:0] b,
  input  logic                    sub,
  output logic signed [ACC_W-1:0] sum,
  output logic                    neg
);

  logic [ACC_W-1:0] b_inv;

  assign b_inv = b ^ {ACC_W{sub}};
  assign sum   = $signed(a + b_inv + {{(ACC_W-1){1'b0}}, sub});
  assign neg   = sum[ACC_W-1];

endmodule

`default_nettype wire

// ===== design/gregorian_day_number_converter_top.sv =====
// ----------------------------------------------------------------------------
// gregorian_day_number_converter_top
// Date <-> day number conversion with signed offset, decoded back to date,
// weekday and leap flag. Sequencer over one shared adder.
// ----------------------------------------------------------------------------
// Flow: a bad year, month or zero day is refused from idle, a day past month
//   end after encode; a day number start skips encode (14 block steps each
//   way and up to 12 month steps, all through the one adder).
// One word at a time: busy holds while converting; next start is taken in the
//   cycle the result is strobed. The receiver cannot stall.
// Reset (rst, synchronous): sequencer idle, done low; result ports keep value.
`default_nettype none
`include "assert_macros.svh"

module gregorian_day_number_converter_top import gdn_pkg::*; #(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [11:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [19:0]        day_number,
  input  logic signed [19:0] day_offset,
  output logic               done,
  output logic [1:0]         status,
  output logic [19:0]        result_day_number,
  output logic [11:0]        result_year,
  output logic [3:0]         result_month,
  output logic [4:0]         result_day,
  output logic [2:0]         weekday,
  output logic               leap_year
);

  localparam int LIMIT     = days_before_year(MAX_YEAR + 1);
  localparam int SUM_MAX_I = (LIMIT < DAY_FIELD_MAX) ? LIMIT : DAY_FIELD_MAX;
  localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(SUM_MAX_I);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENC   = 3'd1;
  localparam logic [2:0] S_EFIX  = 3'd2;
  localparam logic [2:0] S_OFFS  = 3'd3;
  localparam logic [2:0] S_RANGE = 3'd4;
  localparam logic [2:0] S_DPREP = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;
  localparam logic [2:0] S_MON   = 3'd7;

  logic [2:0]              state, state_next;
  logic [STEP_W-1:0]       k, k_next;
  logic signed [ACC_W-1:0] acc, acc_next;
  logic [YR_W-1:0]         yreg, yreg_next;
  logic [1:0]              nb, nb_next;
  logic [4:0]              nc, nc_next;
  logic [1:0]              ne, ne_next;
  logic [2:0]              wk, wk_next;
  logic [3:0]              mon, mon_next;
  logic [3:0]              month_r, month_r_next;
  logic [4:0]              day_r, day_r_next;
  logic signed [19:0]      offset_r, offset_r_next;
  logic [19:0]             sum_r, sum_r_next;

  logic signed [ACC_W-1:0] alu_b, alu_sum;
  logic                    alu_sub, alu_neg;
  logic                    leap, take, fin;
  logic [1:0]              fin_stat;
  logic [4:0]              mlen;
  logic [STEP_W-1:0]       k_inc;
  logic [5:0]              wk_sum;
  logic                    res_clear, res_sane;

  gdn_alu u_alu (
    .a   (acc),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  // leap of 1601 + 400a + 100b + 4c + e
  assign leap   = (ne == 2'd3) && !((nc == 5'd24) && (nb != 2'd3));
  assign mlen   = month_len(mon, leap);
  assign busy   = (state != S_IDLE);
  assign k_inc  = k + 4'd1;
  assign wk_sum = {3'b000, wk} + {1'b0, acc[4:0]};

  always_comb begin
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_ENC:   alu_b = step_days(k);
      S_EFIX:  alu_b = month_base(month_r, leap);
      S_OFFS:  alu_b = {{(ACC_W-20){offset_r[19]}}, offset_r};
      S_DPREP: alu_b = ACC_W'(DAYS_1601_TO_1800 - 1);
      S_DEC: begin
        alu_b   = step_days(k);
        alu_sub = 1'b1;
      end
      S_MON: begin
        alu_b   = $signed({{(ACC_W-5){1'b0}}, mlen});
        alu_sub = 1'b1;
      end
      default: alu_b = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_ENC:   take = (yreg >= step_years(k));
      S_DEC:   take = !alu_neg;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    state_next    = state;
    k_next        = k;
    acc_next      = acc;
    yreg_next     = yreg;
    nb_next       = nb;
    nc_next       = nc;
    ne_next       = ne;
    wk_next       = wk;
    mon_next      = mon;
    month_r_next  = month_r;
    day_r_next    = day_r;
    offset_r_next = offset_r;
    sum_r_next    = sum_r;
    fin           = 1'b0;
    fin_stat      = STAT_OK;

    // block counters, shared by encode and decode walks
    if (take) begin
      if ((k >= STEP_100_FIRST) && (k <= STEP_100_LAST)) begin
        nb_next = nb + 2'd1;
      end else if ((k >= STEP_4_FIRST) && (k <= STEP_4_LAST)) begin
        nc_next = nc + 5'(step_years(k) >> 2);
      end else if (k >= STEP_1_FIRST) begin
        ne_next = ne + 2'd1;
      end
    end

    case (state)
      S_IDLE: begin
        if (start) begin
          month_r_next  = month;
          day_r_next    = day;
          offset_r_next = day_offset;
          k_next        = '0;
          nb_next       = '0;
          nc_next       = '0;
          ne_next       = '0;
          if (func) begin
            acc_next   = $signed({{(ACC_W-20){1'b0}}, day_number});
            state_next = S_OFFS;
          end else if ((year >= 12'(FIRST_YEAR)) && (month >= 4'd1) &&
                       (month <= 4'd12) && (day != 5'd0)) begin
            acc_next   = $signed({{(ACC_W-5){1'b0}}, day});
            yreg_next  = {{(YR_W-12){1'b0}}, year} - YR_W'(EPOCH_YEAR);
            state_next = S_ENC;
          end else begin
            fin      = 1'b1;
            fin_stat = STAT_BAD_DATE;
          end
        end
      end
      S_ENC: begin
        if (take) begin
          acc_next  = alu_sum;
          yreg_next = yreg - step_years(k);
        end
        if (k == STEP_LAST) begin
          state_next = S_EFIX;
        end else begin
          k_next = k_inc;
        end
      end
      S_EFIX: begin
        if (day_r > month_len(month_r, leap)) begin
          fin      = 1'b1;
          fin_stat = STAT_BAD_DATE;
        end else begin
          acc_next   = alu_sum;
          state_next = S_OFFS;
        end
      end
      S_OFFS: begin
        acc_next   = alu_sum;
        state_next = S_RANGE;
      end
      S_RANGE: begin
        if (acc[ACC_W-1] || (acc == '0)) begin
          fin      = 1'b1;
          fin_stat = STAT_LOW;
        end else if (acc > SUM_MAX) begin
          fin      = 1'b1;
          fin_stat = STAT_HIGH;
        end else begin
          sum_r_next = acc[19:0];
          state_next = S_DPREP;
        end
      end
      S_DPREP: begin
        acc_next   = alu_sum;
        yreg_next  = YR_W'(EPOCH_YEAR);
        wk_next    = 3'd1;   // 1 Jan 1601 was a Monday
        k_next     = '0;
        nb_next    = '0;
        nc_next    = '0;
        ne_next    = '0;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (take) begin
          acc_next  = alu_sum;
          yreg_next = yreg + step_years(k);
          wk_next   = add_mod7(wk, step_wk(k));
        end
        if (k == STEP_LAST) begin
          mon_next   = 4'd1;
          state_next = S_MON;
        end else begin
          k_next = k_inc;
        end
      end
      S_MON: begin
        if ((mon != 4'd12) && !alu_neg) begin
          acc_next = alu_sum;
          mon_next = mon + 4'd1;
          wk_next  = add_mod7(wk, mod7_6({1'b0, mlen}));
        end else begin
          fin = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    acc      <= acc_next;
    yreg     <= yreg_next;
    nb       <= nb_next;
    nc       <= nc_next;
    ne       <= ne_next;
    wk       <= wk_next;
    mon      <= mon_next;
    month_r  <= month_r_next;
    day_r    <= day_r_next;
    offset_r <= offset_r_next;
    sum_r    <= sum_r_next;
    if (fin) begin
      status <= fin_stat;
      if (fin_stat == STAT_OK) begin
        result_day_number <= sum_r;
        result_year       <= yreg[11:0];
        result_month      <= mon;
        result_day        <= acc[4:0] + 5'd1;
        weekday           <= mod7_6(wk_sum);
        leap_year         <= leap;
      end else begin
        result_day_number <= '0;
        result_year       <= '0;
        result_month      <= '0;
        result_day        <= '0;
        weekday           <= '0;
        leap_year         <= 1'b0;
      end
    end
  end

  assign res_clear = (result_day_number == 20'd0) && (result_year == 12'd0) &&
                     (result_month == 4'd0) && (result_day == 5'd0) &&
                     (weekday == 3'd0) && !leap_year;
  assign res_sane  = (result_month >= 4'd1) && (result_month <= 4'd12) &&
                     (result_day != 5'd0) && (weekday <= 3'd6) &&
                     (result_day_number != 20'd0);

  `GDN_ASSERT_NXT(a_start_takes, start && !busy, busy || done)
  `GDN_ASSERT_NOW(a_done_idle, done, !busy)
  `GDN_ASSERT_NOW(a_err_zero, done && (status != STAT_OK), res_clear)
  `GDN_ASSERT_NOW(a_ok_fields, done && (status == STAT_OK), res_sane)

endmodule

`default_nettype wire
